@@ sv/kap_pkg.sv @@
// ----------------------------------------------------------------------------
// kap_pkg: shared types and constants for the KISS/AX.25 frame parser
// Byte codes, field kinds, register indexes and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package kap_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned INDEX_W = 9;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INFO_LENGTH = 2'd1;
  localparam logic [CFG_DATA_W-1:0] COMMENT_OFFSET_RST  = 8'd10;
  localparam logic [CFG_DATA_W-1:0] MIN_INFO_LENGTH_RST = 8'd8;

  // Field kinds reported on the output
  localparam logic [KIND_W-1:0] KIND_DEST_CHAR = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEST_SSID = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SRC_CHAR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SRC_SSID  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CONTROL   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_INFO      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FRAME_END = 3'd6;

  // Byte codes
  localparam logic [BYTE_W-1:0] FEND          = 8'hC0;
  localparam logic [BYTE_W-1:0] MICE_BACKTICK = 8'h60;
  localparam logic [BYTE_W-1:0] MICE_QUOTE    = 8'h27;
  localparam logic [BYTE_W-1:0] MICE_OLD_A    = 8'h1C;
  localparam logic [BYTE_W-1:0] MICE_OLD_B    = 8'h1D;
  localparam logic [BYTE_W-1:0] COMMENT_END   = 8'h5F;
  localparam logic [BYTE_W-1:0] PRINT_LO      = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI      = 8'd127;
  localparam logic [BYTE_W-1:0] SSID_MASK     = 8'h0F;

  // Header layout (byte positions inside the frame)
  localparam int unsigned POS_DEST_SSID = 6;
  localparam int unsigned POS_SRC_CHAR  = 7;
  localparam int unsigned POS_SRC_SSID  = 13;
  localparam int unsigned POS_CONTROL   = 14;
  localparam int unsigned POS_INFO      = 16;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  value;
    logic               in_comment;
    logic               mic_e;
    logic               comment_ok;
    logic               overflow;
  } kap_result_t;

endpackage

`default_nettype wire

@@ sv/kiss_ax25_frame_parser.sv @@
// ----------------------------------------------------------------------------
// kiss_ax25_frame_parser: KISS/AX.25 byte stream decoder
// Classifies received bytes by frame position and reports a result per field byte and a summary at each frame end.
// ----------------------------------------------------------------------------
// Pipeline: input register, then decode into the result register.
// Throughput: one byte per cycle unless out_stall_i holds a full result slot; the
//   position counter and frame flags update in the decode cycle, so
//   back-to-back bytes never wait on each other.
// Reset: asynchronous, active low; leaves the parser outside a frame with
//   comment_offset = 10 and min_info_length = 8.
`default_nettype none

module kiss_ax25_frame_parser import kap_pkg::*; #(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [BYTE_W-1:0]     rx_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [KIND_W-1:0]          kind_o,
  output logic [INDEX_W-1:0]         index_o,
  output logic [BYTE_W-1:0]          value_o,
  output logic                       in_comment_o,
  output logic                       mic_e_o,
  output logic                       comment_ok_o,
  output logic                       overflow_o
);

  logic [CFG_DATA_W-1:0] comment_offset_q;
  logic [CFG_DATA_W-1:0] min_info_length_q;

  logic              in_vld_q, in_vld_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              adv;
  logic              free;
  logic              emit;
  kap_result_t       dec_res;
  kap_result_t       out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_offset_q  <= COMMENT_OFFSET_RST;
      min_info_length_q <= MIN_INFO_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COMMENT_OFFSET:  comment_offset_q  <= cfg_wdata_i;
        CFG_MIN_INFO_LENGTH: min_info_length_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // decode the held beat whenever the result slot can take it
  assign adv        = in_vld_q && free;
  assign in_stall_o = in_vld_q && !free;

  always_comb begin
    in_vld_d = in_vld_q;
    if (!in_stall_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  kap_decoder #(
    .MaxFrame (MaxFrame)
  ) u_decoder (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .byte_i            (in_byte_q),
    .comment_offset_i  (comment_offset_q),
    .min_info_length_i (min_info_length_q),
    .emit_o            (emit),
    .result_o          (dec_res)
  );

  kap_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .emit_i      (emit),
    .result_i    (dec_res),
    .out_stall_i (out_stall_i),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign kind_o       = out_res.kind;
  assign index_o      = out_res.index;
  assign value_o      = out_res.value;
  assign in_comment_o = out_res.in_comment;
  assign mic_e_o      = out_res.mic_e;
  assign comment_ok_o = out_res.comment_ok;
  assign overflow_o   = out_res.overflow;

  // frame-end flags appear only on a frame-end beat
  a_end_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KIND_FRAME_END)) |-> (!comment_ok_o && !overflow_o))
    else $error("frame-end flag on a non-frame-end beat");

  // a comment byte only comes from an info byte of a Mic-E frame
  a_comment_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_comment_o) |-> (mic_e_o && (kind_o == KIND_INFO)))
    else $error("comment byte outside Mic-E info");

  // backpressure reaches the input only through a held byte and a full slot
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // a decoded byte that emits lands in the result slot next cycle
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && emit) |=> out_valid_o)
    else $error("emitted result lost");

endmodule

`default_nettype wire

@@ sv/kap_decoder.sv @@
// ----------------------------------------------------------------------------
// kap_decoder: frame state and byte classification
// Holds the per-frame state and turns one byte into at most one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module kap_decoder import kap_pkg::*; #(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire logic [BYTE_W-1:0]     byte_i,
  input  wire logic [CFG_DATA_W-1:0] comment_offset_i,
  input  wire logic [CFG_DATA_W-1:0] min_info_length_i,
  output logic                       emit_o,
  output kap_result_t                result_o
);

  localparam int unsigned PW = $clog2(MaxFrame + 1);
  localparam int unsigned XW = (PW > INDEX_W) ? PW : INDEX_W;

  logic          in_frame_q, in_frame_d;
  logic          skip_q, skip_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          mic_e_q, mic_e_d;
  logic          open_q, open_d;
  logic          good_q, good_d;
  logic          dropped_q, dropped_d;

  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     k_x;
  logic [XW-1:0]     info_len_x;
  logic [BYTE_W-1:0] sh;
  logic              marker;
  logic              mic_now;
  logic              printable;

  assign pos_x      = XW'(pos_q);
  assign k_x        = pos_x - XW'(POS_INFO);
  assign info_len_x = (pos_x > XW'(POS_INFO)) ? k_x : '0;
  assign sh         = byte_i >> 1;
  assign marker     = (byte_i == MICE_BACKTICK) || (byte_i == MICE_QUOTE) ||
                      (byte_i == MICE_OLD_A) || (byte_i == MICE_OLD_B);
  assign mic_now    = (k_x == '0) ? marker : mic_e_q;
  assign printable  = (byte_i >= PRINT_LO) && (byte_i <= PRINT_HI);

  always_comb begin
    in_frame_d = in_frame_q;
    skip_d     = skip_q;
    pos_d      = pos_q;
    mic_e_d    = mic_e_q;
    open_d     = open_q;
    good_d     = good_q;
    dropped_d  = dropped_q;
    emit_o     = 1'b0;
    result_o   = '0;
    result_o.mic_e = mic_e_q;

    if (byte_i == FEND) begin
      if (in_frame_q) begin
        emit_o              = 1'b1;
        result_o.kind       = KIND_FRAME_END;
        result_o.index      = pos_x[INDEX_W-1:0];
        result_o.comment_ok = mic_e_q && good_q &&
                              (info_len_x >= XW'(min_info_length_i));
        result_o.overflow   = dropped_q;
      end
      // a delimiter toggles framing; opening also arms the command-byte skip
      in_frame_d = !in_frame_q;
      skip_d     = !in_frame_q;
      pos_d      = '0;
      mic_e_d    = 1'b0;
      open_d     = 1'b1;
      good_d     = 1'b1;
      dropped_d  = 1'b0;
    end else if (in_frame_q) begin
      if (skip_q) begin
        skip_d = 1'b0;
      end else if (pos_q >= PW'(MaxFrame)) begin
        dropped_d = 1'b1;
      end else begin
        emit_o = 1'b1;
        pos_d  = pos_q + 1'b1;
        if (pos_x < XW'(POS_DEST_SSID)) begin
          result_o.kind  = KIND_DEST_CHAR;
          result_o.index = pos_x[INDEX_W-1:0];
          result_o.value = sh;
        end else if (pos_x == XW'(POS_DEST_SSID)) begin
          result_o.kind  = KIND_DEST_SSID;
          result_o.value = sh & SSID_MASK;
        end else if (pos_x < XW'(POS_SRC_SSID)) begin
          result_o.kind  = KIND_SRC_CHAR;
          result_o.index = INDEX_W'(pos_x - XW'(POS_SRC_CHAR));
          result_o.value = sh;
        end else if (pos_x == XW'(POS_SRC_SSID)) begin
          result_o.kind  = KIND_SRC_SSID;
          result_o.value = sh & SSID_MASK;
        end else if (pos_x < XW'(POS_INFO)) begin
          result_o.kind  = KIND_CONTROL;
          result_o.index = INDEX_W'(pos_x - XW'(POS_CONTROL));
          result_o.value = byte_i;
        end else begin
          result_o.kind  = KIND_INFO;
          result_o.index = k_x[INDEX_W-1:0];
          result_o.value = byte_i;
          result_o.mic_e = mic_now;
          mic_e_d        = mic_now;
          if (mic_now && open_q && (k_x >= XW'(comment_offset_i))) begin
            priority if (byte_i == COMMENT_END) begin
              open_d = 1'b0;
            end else if (printable) begin
              result_o.in_comment = 1'b1;
            end else begin
              // unprintable byte spoils the comment and closes it
              good_d = 1'b0;
              open_d = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      skip_q     <= 1'b0;
      pos_q      <= '0;
      mic_e_q    <= 1'b0;
      open_q     <= 1'b1;
      good_q     <= 1'b1;
      dropped_q  <= 1'b0;
    end else if (adv_i) begin
      in_frame_q <= in_frame_d;
      skip_q     <= skip_d;
      pos_q      <= pos_d;
      mic_e_q    <= mic_e_d;
      open_q     <= open_d;
      good_q     <= good_d;
      dropped_q  <= dropped_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/kap_out_reg.sv @@
// ----------------------------------------------------------------------------
// kap_out_reg: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module kap_out_reg import kap_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic        emit_i,
  input  wire kap_result_t result_i,
  input  wire logic        out_stall_i,
  output logic             free_o,
  output logic             out_valid_o,
  output kap_result_t      result_o
);

  logic        vld_q, vld_d;
  kap_result_t res_q;

  // the slot can take a new beat when empty or drained this cycle
  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = emit_i;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && emit_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire
